// File: hdl/mlsq_pkg.sv
// shared types and constants of the motor load state qualifier
`timescale 1ns / 1ps
`default_nettype none

package mlsq_pkg;

    // group size and field widths
    localparam int SAMPLES_PER_GROUP = 10;
    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 16;
    localparam int AVG_W    = 12;
    localparam int LIMIT_W  = 13;
    localparam int HOLD_W   = 8;
    localparam int STATE_W  = 3;
    localparam int CNT_W    = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1;

    // divide by group size as multiply by rounded-up reciprocal, exact for any sum
    localparam int DIV_L   = $clog2(SAMPLES_PER_GROUP);
    localparam int SHIFT   = SUM_W + DIV_L;
    localparam int RECIP_W = SUM_W + 1;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << SHIFT) + SAMPLES_PER_GROUP - 1) / SAMPLES_PER_GROUP;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_VAL[RECIP_W-1:0];
    localparam int PROD_W  = SUM_W + RECIP_W;

    // queue between front and back, and result queue
    localparam int MQ_DEPTH = 4;
    localparam int MQ_PTR_W = 2;
    localparam int MQ_CNT_W = 3;

    // configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // reset values of the registers
    localparam logic [LIMIT_W-1:0] NOWORK_LIMIT_RST   = 13'd20;
    localparam logic [LIMIT_W-1:0] NOLOAD_LIMIT_RST   = 13'd200;
    localparam logic [LIMIT_W-1:0] GRINDING_LIMIT_RST = 13'd1000;
    localparam logic [HOLD_W-1:0]  HOLD_NOWORK_RST    = 8'd40;
    localparam logic [HOLD_W-1:0]  HOLD_NOLOAD_RST    = 8'd3;
    localparam logic [HOLD_W-1:0]  HOLD_GRINDING_RST  = 8'd3;
    localparam logic [HOLD_W-1:0]  HOLD_STALL_RST     = 8'd2;

    // register indexes
    typedef enum logic [2:0] {
        REG_NOWORK_LIMIT   = 3'd0,
        REG_NOLOAD_LIMIT   = 3'd1,
        REG_GRINDING_LIMIT = 3'd2,
        REG_HOLD_NOWORK    = 3'd3,
        REG_HOLD_NOLOAD    = 3'd4,
        REG_HOLD_GRINDING  = 3'd5,
        REG_HOLD_STALL     = 3'd6
    } reg_index_t;

    // load states
    typedef enum logic [STATE_W-1:0] {
        LS_UNKNOWN  = 3'd0,
        LS_NOWORK   = 3'd1,
        LS_NOLOAD   = 3'd2,
        LS_GRINDING = 3'd3,
        LS_STALL    = 3'd4
    } load_state_t;

    // configuration seen by the back part
    typedef struct packed {
        logic [LIMIT_W-1:0] nowork_limit;
        logic [LIMIT_W-1:0] noload_limit;
        logic [LIMIT_W-1:0] grinding_limit;
        logic [HOLD_W-1:0]  hold_nowork;
        logic [HOLD_W-1:0]  hold_noload;
        logic [HOLD_W-1:0]  hold_grinding;
        logic [HOLD_W-1:0]  hold_stall;
    } cfg_t;

    // one result entry
    typedef struct packed {
        load_state_t        state;
        logic [AVG_W-1:0]   avg;
        logic               changed;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/mlsq_front.sv
// front part: sums samples into groups and queues each finished group sum
`timescale 1ns / 1ps
`default_nettype none

module mlsq_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire logic [mlsq_pkg::SAMPLE_W-1:0] sample,
    output logic                              full,
    output logic                              q_push,
    output logic [mlsq_pkg::SUM_W-1:0]        q_data,
    input  wire logic                         q_full
);

    logic [mlsq_pkg::SUM_W-1:0] sum_reg;
    logic [mlsq_pkg::SUM_W-1:0] sum_next;
    logic [mlsq_pkg::CNT_W-1:0] count_reg;
    logic [mlsq_pkg::CNT_W-1:0] count_next;
    logic                       last_sample;
    logic                       accept;
    logic [mlsq_pkg::SUM_W-1:0] sum_add;

    // only the sample closing a group needs room in the queue
    assign last_sample = (count_reg == mlsq_pkg::CNT_W'(mlsq_pkg::SAMPLES_PER_GROUP - 1));
    assign full        = last_sample && q_full;
    assign accept      = push && !full;
    assign sum_add     = sum_reg + {{(mlsq_pkg::SUM_W - mlsq_pkg::SAMPLE_W){1'b0}}, sample};

    // group sum handoff
    assign q_push = accept && last_sample;
    assign q_data = sum_add;

    // accumulator and sample counter
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (last_sample)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_add;
                count_next = count_reg + mlsq_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/mlsq_queue.sv
// short queue of group sums between front and back parts
`timescale 1ns / 1ps
`default_nettype none

module mlsq_queue (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire logic [mlsq_pkg::SUM_W-1:0] push_data,
    output logic                           full,
    input  wire logic                      pop,
    output logic [mlsq_pkg::SUM_W-1:0]     pop_data,
    output logic                           empty
);

    logic [mlsq_pkg::SUM_W-1:0]    mem [mlsq_pkg::MQ_DEPTH];
    logic [mlsq_pkg::MQ_PTR_W-1:0] wr_ptr_reg;
    logic [mlsq_pkg::MQ_PTR_W-1:0] rd_ptr_reg;
    logic [mlsq_pkg::MQ_CNT_W-1:0] count_reg;
    logic [mlsq_pkg::MQ_CNT_W-1:0] count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full     = (count_reg == mlsq_pkg::MQ_CNT_W'(mlsq_pkg::MQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + mlsq_pkg::MQ_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - mlsq_pkg::MQ_CNT_W'(1);
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + mlsq_pkg::MQ_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + mlsq_pkg::MQ_PTR_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/mlsq_back.sv
// back part: averages each group, qualifies the load state, queues results
`timescale 1ns / 1ps
`default_nettype none

module mlsq_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mlsq_pkg::cfg_t              cfg,
    input  wire logic                        q_empty,
    input  wire logic [mlsq_pkg::SUM_W-1:0]  q_data,
    output logic                             q_pop,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [mlsq_pkg::STATE_W-1:0]     load_state,
    output logic [mlsq_pkg::AVG_W-1:0]       group_average,
    output logic                             state_changed
);

    // average stage
    logic                          avg_valid_reg;
    logic [mlsq_pkg::AVG_W-1:0]    avg_reg;
    logic [mlsq_pkg::PROD_W-1:0]   prod;

    // qualifier state
    mlsq_pkg::load_state_t         state_reg;
    mlsq_pkg::load_state_t         state_next;
    logic [mlsq_pkg::HOLD_W-1:0]   pending_reg;
    logic [mlsq_pkg::HOLD_W-1:0]   pending_next;
    logic [mlsq_pkg::HOLD_W-1:0]   pending_inc;
    logic [mlsq_pkg::HOLD_W-1:0]   hold;
    logic [mlsq_pkg::LIMIT_W-1:0]  avg_ext;
    mlsq_pkg::load_state_t         cls;
    logic                          changed;

    // result queue
    mlsq_pkg::result_t             res_mem [mlsq_pkg::MQ_DEPTH];
    mlsq_pkg::result_t             res_head;
    logic [mlsq_pkg::MQ_PTR_W-1:0] res_wr_reg;
    logic [mlsq_pkg::MQ_PTR_W-1:0] res_rd_reg;
    logic [mlsq_pkg::MQ_CNT_W-1:0] res_cnt_reg;
    logic [mlsq_pkg::MQ_CNT_W-1:0] res_cnt_next;
    logic [mlsq_pkg::MQ_CNT_W-1:0] res_claimed;
    logic                          res_pop;

    // take a sum only when a result slot is reserved for it
    assign res_claimed = res_cnt_reg + mlsq_pkg::MQ_CNT_W'(avg_valid_reg);
    assign q_pop = !q_empty && (res_claimed < mlsq_pkg::MQ_CNT_W'(mlsq_pkg::MQ_DEPTH));

    // reciprocal multiply gives the truncated average
    assign prod = mlsq_pkg::PROD_W'(q_data) * mlsq_pkg::PROD_W'(mlsq_pkg::RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_valid_reg <= 1'b0;
        end
        else
        begin
            avg_valid_reg <= q_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            avg_reg <= prod[mlsq_pkg::SHIFT +: mlsq_pkg::AVG_W];
        end
    end

    // class by thresholds, first test that holds decides
    assign avg_ext = {1'b0, avg_reg};

    always_comb
    begin
        if (avg_ext < cfg.nowork_limit)
        begin
            cls = mlsq_pkg::LS_NOWORK;
        end
        else if (avg_ext < cfg.noload_limit)
        begin
            cls = mlsq_pkg::LS_NOLOAD;
        end
        else if (avg_ext < cfg.grinding_limit)
        begin
            cls = mlsq_pkg::LS_GRINDING;
        end
        else
        begin
            cls = mlsq_pkg::LS_STALL;
        end
    end

    // hold count of the class
    always_comb
    begin
        case (cls)
            mlsq_pkg::LS_NOWORK:   hold = cfg.hold_nowork;
            mlsq_pkg::LS_NOLOAD:   hold = cfg.hold_noload;
            mlsq_pkg::LS_GRINDING: hold = cfg.hold_grinding;
            default:               hold = cfg.hold_stall;
        endcase
    end

    // pending counter saturates when full
    assign pending_inc = (pending_reg == {mlsq_pkg::HOLD_W{1'b1}}) ?
                         pending_reg : pending_reg + mlsq_pkg::HOLD_W'(1);

    // state qualification
    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        changed      = 1'b0;
        if (avg_valid_reg)
        begin
            if (cls != state_reg)
            begin
                pending_next = pending_inc;
                if (pending_inc >= hold)
                begin
                    state_next = cls;
                    changed    = 1'b1;
                end
            end
            else
            begin
                pending_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mlsq_pkg::LS_UNKNOWN;
            pending_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

    // result queue occupancy and pointers
    assign empty   = (res_cnt_reg == '0);
    assign res_pop = pop && !empty;

    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        if (avg_valid_reg && !res_pop)
        begin
            res_cnt_next = res_cnt_reg + mlsq_pkg::MQ_CNT_W'(1);
        end
        else if (res_pop && !avg_valid_reg)
        begin
            res_cnt_next = res_cnt_reg - mlsq_pkg::MQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            res_cnt_reg <= res_cnt_next;
            if (avg_valid_reg)
            begin
                res_wr_reg <= res_wr_reg + mlsq_pkg::MQ_PTR_W'(1);
            end
            if (res_pop)
            begin
                res_rd_reg <= res_rd_reg + mlsq_pkg::MQ_PTR_W'(1);
            end
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (avg_valid_reg)
        begin
            res_mem[res_wr_reg] <= '{state: state_next, avg: avg_reg, changed: changed};
        end
    end

    // oldest result on the ports
    assign res_head      = res_mem[res_rd_reg];
    assign load_state    = res_head.state;
    assign group_average = res_head.avg;
    assign state_changed = res_head.changed;

endmodule

`default_nettype wire

// File: hdl/motor_load_state_qualifier.sv
// top level: configuration registers and the front, queue and back parts
`timescale 1ns / 1ps
`default_nettype none

// channel   | signals                                   | transfer when
// ----------+-------------------------------------------+---------------------------------
// input     | push, full, sample                        | push && !full
// result    | pop, empty, load_state, group_average,    | pop && !empty
//           | state_changed                             |
// config    | psel, penable, pwrite, paddr, pwdata,     | psel && penable && pwrite
//           | prdata, pready                            |
//
// one sample is taken every cycle while full is low; a group sum passes the sum queue,
// the reciprocal multiply register and the result queue before it shows on the result ports.
// reset clears the sums, counters, queues and state and loads the default registers.
// full rises only for a group's last sample while the four-entry sum queue is full;
// that queue fills when the four-entry result queue is held by an idle consumer.

module motor_load_state_qualifier (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [mlsq_pkg::SAMPLE_W-1:0] sample,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [mlsq_pkg::STATE_W-1:0]       load_state,
    output logic [mlsq_pkg::AVG_W-1:0]         group_average,
    output logic                               state_changed,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mlsq_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [mlsq_pkg::PDATA_W-1:0]  pwdata,
    output logic [mlsq_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    mlsq_pkg::cfg_t              cfg_reg;
    mlsq_pkg::cfg_t              cfg_next;
    mlsq_pkg::reg_index_t        reg_index;
    logic                        wr_en;
    logic                        q_push;
    logic [mlsq_pkg::SUM_W-1:0]  q_wdata;
    logic                        q_full;
    logic                        q_pop;
    logic [mlsq_pkg::SUM_W-1:0]  q_rdata;
    logic                        q_empty;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign reg_index = mlsq_pkg::reg_index_t'(paddr[4:2]);

    // register writes, values cut to register width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                mlsq_pkg::REG_NOWORK_LIMIT:   cfg_next.nowork_limit   = pwdata[12:0];
                mlsq_pkg::REG_NOLOAD_LIMIT:   cfg_next.noload_limit   = pwdata[12:0];
                mlsq_pkg::REG_GRINDING_LIMIT: cfg_next.grinding_limit = pwdata[12:0];
                mlsq_pkg::REG_HOLD_NOWORK:    cfg_next.hold_nowork    = pwdata[7:0];
                mlsq_pkg::REG_HOLD_NOLOAD:    cfg_next.hold_noload    = pwdata[7:0];
                mlsq_pkg::REG_HOLD_GRINDING:  cfg_next.hold_grinding  = pwdata[7:0];
                mlsq_pkg::REG_HOLD_STALL:     cfg_next.hold_stall     = pwdata[7:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nowork_limit   <= mlsq_pkg::NOWORK_LIMIT_RST;
            cfg_reg.noload_limit   <= mlsq_pkg::NOLOAD_LIMIT_RST;
            cfg_reg.grinding_limit <= mlsq_pkg::GRINDING_LIMIT_RST;
            cfg_reg.hold_nowork    <= mlsq_pkg::HOLD_NOWORK_RST;
            cfg_reg.hold_noload    <= mlsq_pkg::HOLD_NOLOAD_RST;
            cfg_reg.hold_grinding  <= mlsq_pkg::HOLD_GRINDING_RST;
            cfg_reg.hold_stall     <= mlsq_pkg::HOLD_STALL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register reads
    always_comb
    begin
        case (reg_index)
            mlsq_pkg::REG_NOWORK_LIMIT:   prdata = 32'(cfg_reg.nowork_limit);
            mlsq_pkg::REG_NOLOAD_LIMIT:   prdata = 32'(cfg_reg.noload_limit);
            mlsq_pkg::REG_GRINDING_LIMIT: prdata = 32'(cfg_reg.grinding_limit);
            mlsq_pkg::REG_HOLD_NOWORK:    prdata = 32'(cfg_reg.hold_nowork);
            mlsq_pkg::REG_HOLD_NOLOAD:    prdata = 32'(cfg_reg.hold_noload);
            mlsq_pkg::REG_HOLD_GRINDING:  prdata = 32'(cfg_reg.hold_grinding);
            mlsq_pkg::REG_HOLD_STALL:     prdata = 32'(cfg_reg.hold_stall);
            default:                      prdata = '0;
        endcase
    end

    // sample accumulation
    mlsq_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .sample (sample),
        .full   (full),
        .q_push (q_push),
        .q_data (q_wdata),
        .q_full (q_full)
    );

    // group sum queue
    mlsq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    // averaging, qualification and results
    mlsq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_data        (q_rdata),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .load_state    (load_state),
        .group_average (group_average),
        .state_changed (state_changed)
    );

endmodule

`default_nettype wire
